FILE: rtl/core/rpcc_pkg.sv
package rpcc_pkg;

  localparam int COORD_W  = 52;
  localparam int SPEED_W  = 11;
  localparam int PAIR_W   = 17;
  localparam int HELD_W   = 10;
  localparam int CFG_IDX_W = 1;

  localparam logic signed [COORD_W-1:0] WINDOW_LOW_RST  = 52'sd200000000000000;
  localparam logic signed [COORD_W-1:0] WINDOW_HIGH_RST = 52'sd400000000000000;
  localparam logic [PAIR_W-1:0] PAIR_MAX = {PAIR_W{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW_LOW  = 1'b0,
    REG_WINDOW_HIGH = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [COORD_W-1:0] sx;
    logic [COORD_W-1:0] sy;
    logic [SPEED_W-1:0] vx;
    logic [SPEED_W-1:0] vy;
  } ray_t;

  typedef struct packed {
    logic busy;
    logic hit;
  } pu_stat_t;

endpackage

FILE: rtl/core/rpcc_if.sv
interface rpcc_in_if;
  logic                              valid;
  logic                              ready;
  logic                              first;
  logic signed [rpcc_pkg::COORD_W-1:0] start_x;
  logic signed [rpcc_pkg::COORD_W-1:0] start_y;
  logic signed [rpcc_pkg::SPEED_W-1:0] speed_x;
  logic signed [rpcc_pkg::SPEED_W-1:0] speed_y;
  modport source (output valid, first, start_x, start_y, speed_x, speed_y, input ready);
  modport sink   (input valid, first, start_x, start_y, speed_x, speed_y, output ready);
endinterface

interface rpcc_out_if;
  logic                        valid;
  logic                        ready;
  logic [rpcc_pkg::PAIR_W-1:0] pair_total;
  logic [rpcc_pkg::HELD_W-1:0] rays_held;
  logic                        table_full;
  modport source (output valid, pair_total, rays_held, table_full, input ready);
  modport sink   (input valid, pair_total, rays_held, table_full, output ready);
endinterface

interface rpcc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [rpcc_pkg::CFG_IDX_W-1:0]      index;
  logic signed [rpcc_pkg::COORD_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/ray_pair_crossing_counter.sv
// channel  dir  transaction
// in_ch    in   first, start_x, start_y, speed_x, speed_y
// out_ch   out  pair_total, rays_held, table_full
// cfg_ch   in   index (window_low, window_high), data
//
// each ray scans the table: one stored ray a cycle through the pipelined pair
// test, read from the ray memory, then drain
// a new ray is taken while a result still waits, the next result waits for out_ch
// synchronous active-low reset clears count and ray count, sets windows to reset values; no clearing pass
module ray_pair_crossing_counter #(
  parameter int MAX_RAYS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  rpcc_in_if.sink     in_ch,
  rpcc_out_if.source  out_ch,
  rpcc_cfg_if.sink    cfg_ch
);

  localparam int AW = $clog2(MAX_RAYS);
  localparam int CW = $clog2(MAX_RAYS + 1);
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_RAYS);

  rpcc_pkg::state_t state_r, state_nxt;
  rpcc_pkg::ray_t   cur_r, rd_data;
  rpcc_pkg::pu_stat_t stat;

  logic signed [rpcc_pkg::COORD_W-1:0] win_lo_r, win_hi_r;
  logic [CW-1:0] cnt_r, cnt_nxt, idx_r;
  logic [rpcc_pkg::PAIR_W-1:0] pair_r, pair_nxt;
  logic in_fire, issue, done_fire, full, out_valid_r;
  logic [rpcc_pkg::PAIR_W-1:0] out_pair_r;
  logic [rpcc_pkg::HELD_W-1:0] out_held_r;
  logic out_full_r;

  assign in_fire = in_ch.valid & in_ch.ready;
  assign full    = (cnt_r == MAX_CNT);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rpcc_pkg::ST_IDLE:  if (in_fire) state_nxt = rpcc_pkg::ST_SCAN;
      rpcc_pkg::ST_SCAN:  if (idx_r == cnt_r) state_nxt = rpcc_pkg::ST_DRAIN;
      rpcc_pkg::ST_DRAIN: if (!stat.busy) state_nxt = rpcc_pkg::ST_DONE;
      rpcc_pkg::ST_DONE:  if (!out_valid_r || out_ch.ready) state_nxt = rpcc_pkg::ST_IDLE;
      default:            state_nxt = rpcc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = 1'b0;
    issue       = 1'b0;
    done_fire   = 1'b0;
    case (state_r)
      rpcc_pkg::ST_IDLE:  in_ch.ready = 1'b1;
      rpcc_pkg::ST_SCAN:  issue = (idx_r != cnt_r);
      rpcc_pkg::ST_DRAIN: ;
      rpcc_pkg::ST_DONE:  done_fire = !out_valid_r || out_ch.ready;
      default:            ;
    endcase
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    pair_nxt = pair_r;
    if (in_fire && in_ch.first) begin
      cnt_nxt  = '0;
      pair_nxt = '0;
    end else if (stat.hit && pair_r != rpcc_pkg::PAIR_MAX) begin
      pair_nxt = pair_r + 1'b1;
    end
    if (done_fire && !full) begin
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpcc_pkg::ST_IDLE;
      cnt_r       <= '0;
      pair_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
      win_lo_r    <= rpcc_pkg::WINDOW_LOW_RST;
      win_hi_r    <= rpcc_pkg::WINDOW_HIGH_RST;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      pair_r  <= pair_nxt;
      if (in_fire) begin
        idx_r <= '0;
      end else if (issue) begin
        idx_r <= idx_r + 1'b1;
      end
      if (done_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_ch.valid) begin
        case (rpcc_pkg::cfg_reg_t'(cfg_ch.index))
          rpcc_pkg::REG_WINDOW_LOW:  win_lo_r <= cfg_ch.data;
          rpcc_pkg::REG_WINDOW_HIGH: win_hi_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_r <= '{sx: in_ch.start_x, sy: in_ch.start_y, vx: in_ch.speed_x, vy: in_ch.speed_y};
    end
    if (done_fire) begin
      out_pair_r <= pair_r;
      out_held_r <= rpcc_pkg::HELD_W'(cnt_nxt);
      out_full_r <= full;
    end
  end

  rpcc_store #(.DEPTH(MAX_RAYS)) u_store (
    .clk     (clk),
    .we      (done_fire && !full),
    .waddr   (cnt_r[AW-1:0]),
    .wdata   (cur_r),
    .raddr   (idx_r[AW-1:0]),
    .rdata_r (rd_data)
  );

  rpcc_pair_unit u_pair (
    .clk    (clk),
    .rst_n  (rst_n),
    .issue  (issue),
    .q      (rd_data),
    .cur    (cur_r),
    .win_lo (win_lo_r),
    .win_hi (win_hi_r),
    .stat   (stat)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pair_total = out_pair_r;
  assign out_ch.rays_held  = out_held_r;
  assign out_ch.table_full = out_full_r;

endmodule

FILE: rtl/core/rpcc_store.sv
module rpcc_store #(
  parameter int DEPTH = 512,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [AW-1:0]        waddr,
  input  rpcc_pkg::ray_t       wdata,
  input  logic [AW-1:0]        raddr,
  output rpcc_pkg::ray_t       rdata_r
);

  rpcc_pkg::ray_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/core/rpcc_pair_unit.sv
module rpcc_pair_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                issue,
  input  rpcc_pkg::ray_t                      q,
  input  rpcc_pkg::ray_t                      cur,
  input  logic signed [rpcc_pkg::COORD_W-1:0] win_lo,
  input  logic signed [rpcc_pkg::COORD_W-1:0] win_hi,
  output rpcc_pkg::pu_stat_t                  stat
);

  logic signed [51:0] qx, qy, px, py;
  logic signed [10:0] qvx, qvy, vx, vy;

  logic v0_r, va_r, vb_r, vc_r, vd_r, hit_r;

  logic signed [52:0] a_dx_nxt, a_dy_nxt, a_lx_nxt, a_hx_nxt, a_ly_nxt, a_hy_nxt;
  logic signed [52:0] a_dx_r, a_dy_r, a_lx_r, a_hx_r, a_ly_r, a_hy_r;
  logic signed [21:0] a_d1_nxt, a_d2_nxt, a_d1_r, a_d2_r;
  logic signed [10:0] a_qvx_r, a_qvy_r;

  logic signed [22:0] b_den_nxt, b_den_r;
  logic signed [65:0] b_n1_nxt, b_n2_nxt, b_n1_r, b_n2_r;
  logic signed [52:0] b_lx_r, b_hx_r, b_ly_r, b_hy_r;
  logic signed [10:0] b_qvx_r, b_qvy_r;

  logic signed [76:0] c_sx_nxt, c_sy_nxt, c_lx_nxt, c_hx_nxt, c_ly_nxt, c_hy_nxt;
  logic signed [76:0] c_sx_r, c_sy_r, c_lx_r, c_hx_r, c_ly_r, c_hy_r;
  logic c_neg_r, c_zero_r, c_nok_r;
  logic hit_nxt, in_x, in_y;

  assign qx  = $signed(q.sx);
  assign qy  = $signed(q.sy);
  assign qvx = $signed(q.vx);
  assign qvy = $signed(q.vy);
  assign px  = $signed(cur.sx);
  assign py  = $signed(cur.sy);
  assign vx  = $signed(cur.vx);
  assign vy  = $signed(cur.vy);

  // stage a: offsets and velocity products
  always_comb begin
    a_dx_nxt = px - qx;
    a_dy_nxt = py - qy;
    a_lx_nxt = win_lo - qx;
    a_hx_nxt = win_hi - qx;
    a_ly_nxt = win_lo - qy;
    a_hy_nxt = win_hi - qy;
    a_d1_nxt = qvx * vy;
    a_d2_nxt = qvy * vx;
  end

  // stage b: denominator and crossing numerators
  always_comb begin
    b_den_nxt = a_d1_r - a_d2_r;
    b_n1_nxt  = a_dx_r * vy - a_dy_r * vx;
    b_n2_nxt  = a_dx_r * a_qvy_r - a_dy_r * a_qvx_r;
  end

  // stage c: scaled crossing point against scaled window bounds
  always_comb begin
    c_sx_nxt = b_qvx_r * b_n1_r;
    c_sy_nxt = b_qvy_r * b_n1_r;
    c_lx_nxt = b_lx_r * b_den_r;
    c_hx_nxt = b_hx_r * b_den_r;
    c_ly_nxt = b_ly_r * b_den_r;
    c_hy_nxt = b_hy_r * b_den_r;
  end

  // negative denominator flips every bound
  always_comb begin
    if (c_neg_r) begin
      in_x = (c_hx_r <= c_sx_r) && (c_sx_r <= c_lx_r);
      in_y = (c_hy_r <= c_sy_r) && (c_sy_r <= c_ly_r);
    end else begin
      in_x = (c_lx_r <= c_sx_r) && (c_sx_r <= c_hx_r);
      in_y = (c_ly_r <= c_sy_r) && (c_sy_r <= c_hy_r);
    end
    hit_nxt = !c_zero_r && !c_nok_r && in_x && in_y;
  end

  always_ff @(posedge clk) begin
    a_dx_r  <= a_dx_nxt;
    a_dy_r  <= a_dy_nxt;
    a_lx_r  <= a_lx_nxt;
    a_hx_r  <= a_hx_nxt;
    a_ly_r  <= a_ly_nxt;
    a_hy_r  <= a_hy_nxt;
    a_d1_r  <= a_d1_nxt;
    a_d2_r  <= a_d2_nxt;
    a_qvx_r <= qvx;
    a_qvy_r <= qvy;

    b_den_r <= b_den_nxt;
    b_n1_r  <= b_n1_nxt;
    b_n2_r  <= b_n2_nxt;
    b_lx_r  <= a_lx_r;
    b_hx_r  <= a_hx_r;
    b_ly_r  <= a_ly_r;
    b_hy_r  <= a_hy_r;
    b_qvx_r <= a_qvx_r;
    b_qvy_r <= a_qvy_r;

    c_sx_r   <= c_sx_nxt;
    c_sy_r   <= c_sy_nxt;
    c_lx_r   <= c_lx_nxt;
    c_hx_r   <= c_hx_nxt;
    c_ly_r   <= c_ly_nxt;
    c_hy_r   <= c_hy_nxt;
    c_neg_r  <= b_den_r[22];
    c_zero_r <= (b_den_r == '0);
    c_nok_r  <= b_den_r[22] ? ((b_n1_r > 0) || (b_n2_r > 0))
                            : (b_n1_r[65] || b_n2_r[65]);
    hit_r    <= hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      v0_r <= issue;
      va_r <= v0_r;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
    end
  end

  assign stat.busy = v0_r | va_r | vb_r | vc_r | vd_r;
  assign stat.hit  = vd_r & hit_r;

endmodule

FILE: rtl/core/rpcc_checker.sv
module rpcc_checker #(
  parameter int MAX_RAYS = 512
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rpcc_pkg::HELD_W-1:0] rays_held,
  input logic                        table_full
);

  localparam logic [rpcc_pkg::HELD_W-1:0] MAX_HELD = rpcc_pkg::HELD_W'(MAX_RAYS);

  // busy after every input transaction
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken while still busy");

  // a fresh result only ever follows a busy cycle
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result without work");

  // dropped ray only with a full table
  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && table_full) |-> (rays_held == MAX_HELD))
    else $error("table_full with wrong ray count");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(rays_held) && $stable(table_full)))
    else $error("stalled result changed");

endmodule

bind ray_pair_crossing_counter rpcc_checker #(.MAX_RAYS(MAX_RAYS)) u_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .rays_held  (out_ch.rays_held),
  .table_full (out_ch.table_full)
);

FILE: tb/pair_checker.sv
`timescale 1ns / 100ps

module pair_checker #(
  parameter int MAX_RAYS = 512
) (
  input  logic clk,
  input  logic rst_n,
  rpcc_in_if   in_ch,
  rpcc_out_if  out_ch,
  rpcc_cfg_if  cfg_ch,
  output int   fail_count,
  output int   pending
);

  typedef logic signed [127:0] wide_t;

  typedef struct {
    logic [rpcc_pkg::PAIR_W-1:0] pair_total;
    logic [rpcc_pkg::HELD_W-1:0] rays_held;
    logic                        table_full;
  } tally_t;

  tally_t tally_q[$];

  logic signed [rpcc_pkg::COORD_W-1:0] sx_mem[MAX_RAYS];
  logic signed [rpcc_pkg::COORD_W-1:0] sy_mem[MAX_RAYS];
  logic signed [rpcc_pkg::SPEED_W-1:0] vx_mem[MAX_RAYS];
  logic signed [rpcc_pkg::SPEED_W-1:0] vy_mem[MAX_RAYS];
  int                                  held;
  logic [rpcc_pkg::PAIR_W-1:0]         pairs;
  logic signed [rpcc_pkg::COORD_W-1:0] win_lo;
  logic signed [rpcc_pkg::COORD_W-1:0] win_hi;

  // crossing point inside the window along one axis, den already positive
  function automatic bit axis_inside(wide_t p, wide_t v, wide_t n, wide_t den,
                                     wide_t lo, wide_t hi);
    wide_t s, lb, hb;
    s  = v * n;
    lb = (lo - p) * den;
    hb = (hi - p) * den;
    return (s >= lb) && (s <= hb);
  endfunction

  function automatic bit rays_cross(wide_t p1x, wide_t p1y, wide_t v1x, wide_t v1y,
                                    wide_t p2x, wide_t p2y, wide_t v2x, wide_t v2y,
                                    wide_t lo, wide_t hi);
    wide_t den, dx, dy, n1, n2;
    den = v1x * v2y - v1y * v2x;
    if (den == 0) return 1'b0;
    dx = p2x - p1x;
    dy = p2y - p1y;
    n1 = dx * v2y - dy * v2x;
    n2 = dx * v1y - dy * v1x;
    if (den < 0) begin
      den = -den;
      n1  = -n1;
      n2  = -n2;
    end
    if (n1 < 0 || n2 < 0) return 1'b0;
    return axis_inside(p1x, v1x, n1, den, lo, hi) && axis_inside(p1y, v1y, n1, den, lo, hi);
  endfunction

  always @(posedge clk) begin
    tally_t exp_t, got_t;
    wide_t  px, py, vx, vy, qx, qy, qvx, qvy, lo, hi;
    if (!rst_n) begin
      held       = 0;
      pairs      = '0;
      win_lo     = rpcc_pkg::WINDOW_LOW_RST;
      win_hi     = rpcc_pkg::WINDOW_HIGH_RST;
      fail_count = 0;
      tally_q.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (rpcc_pkg::cfg_reg_t'(cfg_ch.index) == rpcc_pkg::REG_WINDOW_LOW) win_lo = cfg_ch.data;
        else win_hi = cfg_ch.data;
      end
      if (in_ch.valid && in_ch.ready) begin
        px = in_ch.start_x;
        py = in_ch.start_y;
        vx = in_ch.speed_x;
        vy = in_ch.speed_y;
        lo = win_lo;
        hi = win_hi;
        if (in_ch.first) begin
          held  = 0;
          pairs = '0;
        end
        for (int i = 0; i < held; i++) begin
          qx  = sx_mem[i];
          qy  = sy_mem[i];
          qvx = vx_mem[i];
          qvy = vy_mem[i];
          if (rays_cross(qx, qy, qvx, qvy, px, py, vx, vy, lo, hi) &&
              pairs != rpcc_pkg::PAIR_MAX)
            pairs = pairs + 1'b1;
        end
        exp_t.table_full = 1'b0;
        if (held < MAX_RAYS) begin
          sx_mem[held] = in_ch.start_x;
          sy_mem[held] = in_ch.start_y;
          vx_mem[held] = in_ch.speed_x;
          vy_mem[held] = in_ch.speed_y;
          held++;
        end else begin
          exp_t.table_full = 1'b1;
        end
        exp_t.pair_total = pairs;
        exp_t.rays_held  = rpcc_pkg::HELD_W'(held);
        tally_q.push_back(exp_t);
      end
      if (out_ch.valid && out_ch.ready) begin
        got_t.pair_total = out_ch.pair_total;
        got_t.rays_held  = out_ch.rays_held;
        got_t.table_full = out_ch.table_full;
        if (tally_q.size() == 0) begin
          $display("%0t: unexpected result pair_total=%0d rays_held=%0d table_full=%0d",
                   $time, got_t.pair_total, got_t.rays_held, got_t.table_full);
          fail_count++;
        end else begin
          exp_t = tally_q.pop_front();
          if (got_t.pair_total !== exp_t.pair_total || got_t.rays_held !== exp_t.rays_held ||
              got_t.table_full !== exp_t.table_full) begin
            $display("%0t: mismatch expected %0d/%0d/%0d actual %0d/%0d/%0d", $time,
                     exp_t.pair_total, exp_t.rays_held, exp_t.table_full,
                     got_t.pair_total, got_t.rays_held, got_t.table_full);
            fail_count++;
          end
        end
      end
    end
    pending = tally_q.size();
  end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;

  localparam int MAX_RAYS = 512;
  localparam logic signed [rpcc_pkg::COORD_W-1:0] COORD_MIN =
    {1'b1, {(rpcc_pkg::COORD_W-1){1'b0}}};
  localparam logic signed [rpcc_pkg::COORD_W-1:0] COORD_MAX =
    {1'b0, {(rpcc_pkg::COORD_W-1){1'b1}}};

  logic clk;
  logic rst_n;
  int   fail_count;
  int   pending;
  int   cyc;
  bit   hold_req;
  bit   hold_done;
  bit   quiet;

  rpcc_in_if  in_ch();
  rpcc_out_if out_ch();
  rpcc_cfg_if cfg_ch();

  ray_pair_crossing_counter #(.MAX_RAYS(MAX_RAYS)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  pair_checker #(.MAX_RAYS(MAX_RAYS)) u_checker (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  always @(posedge clk) begin
    cyc   <= cyc + 1;
    quiet <= (cyc >= 30000 && cyc < 70000);
  end

  // receiver, with one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (3000) @(posedge clk);
      end
      out_ch.ready <= quiet || ($urandom_range(0, 99) >= 9);
    end
  end

  function automatic logic signed [rpcc_pkg::COORD_W-1:0] near_coord(int span);
    return rpcc_pkg::COORD_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  function automatic logic signed [rpcc_pkg::COORD_W-1:0] any_coord();
    return rpcc_pkg::COORD_W'({$urandom, $urandom});
  endfunction

  function automatic logic signed [rpcc_pkg::SPEED_W-1:0] any_speed();
    if ($urandom_range(0, 19) == 0) return '0;
    return rpcc_pkg::SPEED_W'($urandom);
  endfunction

  task automatic send_ray(bit fst, logic signed [rpcc_pkg::COORD_W-1:0] x,
                          logic signed [rpcc_pkg::COORD_W-1:0] y,
                          logic signed [rpcc_pkg::SPEED_W-1:0] vx,
                          logic signed [rpcc_pkg::SPEED_W-1:0] vy);
    while (!quiet && $urandom_range(0, 99) < 9) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.first   <= fst;
    in_ch.start_x <= x;
    in_ch.start_y <= y;
    in_ch.speed_x <= vx;
    in_ch.speed_y <= vy;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic send_random(bit fst, int span);
    if ($urandom_range(0, 9) == 0)
      send_ray(fst, any_coord(), any_coord(), any_speed(), any_speed());
    else
      send_ray(fst, near_coord(span), near_coord(span), any_speed(), any_speed());
  endtask

  task automatic set_window(logic signed [rpcc_pkg::COORD_W-1:0] lo,
                            logic signed [rpcc_pkg::COORD_W-1:0] hi);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= rpcc_pkg::REG_WINDOW_LOW;
    cfg_ch.data  <= lo;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= rpcc_pkg::REG_WINDOW_HIGH;
    cfg_ch.data  <= hi;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    int n;
    hold_req      = 1'b0;
    rst_n        <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.first  <= 1'b0;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    in_ch.speed_x <= '0;
    in_ch.speed_y <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= rpcc_pkg::REG_WINDOW_LOW;
    cfg_ch.data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // field extremes under the reset window
    send_ray(1'b1, COORD_MIN, COORD_MAX, -11'sd1024, 11'sd1023);
    send_ray(1'b0, COORD_MAX, COORD_MIN, 11'sd1023, -11'sd1024);
    send_ray(1'b0, 52'sd300000000000000, 52'sd100000000000000, 11'sd0, 11'sd7);
    send_ray(1'b0, 52'sd100000000000000, 52'sd300000000000000, 11'sd5, 11'sd0);
    send_ray(1'b0, '0, '0, '0, '0);

    set_window(52'sd0, 52'sd100);
    send_ray(1'b1, 52'sd0, 52'sd0, 11'sd1, 11'sd1);
    send_ray(1'b0, 52'sd100, 52'sd0, -11'sd1, 11'sd1);
    send_ray(1'b0, 52'sd0, 52'sd10, 11'sd1, 11'sd1);   // parallel
    send_ray(1'b0, 52'sd20, 52'sd20, 11'sd0, 11'sd0);  // still
    send_ray(1'b0, 52'sd50, 52'sd50, 11'sd1, 11'sd0);  // crossing at time zero
    send_ray(1'b0, 52'sd0, 52'sd100, 11'sd1, -11'sd1);
    send_ray(1'b0, 52'sd100, 52'sd100, 11'sd3, 11'sd2);
    send_ray(1'b0, 52'sd0, 52'sd101, 11'sd1, -11'sd1);
    send_ray(1'b0, -52'sd5, 52'sd50, 11'sd1, 11'sd0);

    // fill the table past its end; long hold-off first
    set_window(-52'sd1000, 52'sd1000);
    hold_req = 1'b1;
    for (int i = 0; i < MAX_RAYS + 8; i++) send_random(i == 0, 2000);

    set_window(COORD_MIN, COORD_MAX);
    for (int i = 0; i < 20; i++) send_random(i == 0, 1 << 20);

    set_window(52'sd500, -52'sd500);
    for (int i = 0; i < 10; i++) send_random(i == 0, 1000);

    set_window(-52'sd3000, 52'sd2000);
    for (int g = 0; g < 5; g++) begin
      n = $urandom_range(4, 12);
      for (int i = 0; i < n; i++) send_random(i == 0, 3000);
    end

    set_window(rpcc_pkg::WINDOW_LOW_RST, rpcc_pkg::WINDOW_HIGH_RST);
    for (int i = 0; i < 10; i++)
      send_ray(i == 0, 52'sd300000000000000 + near_coord(1 << 30),
               52'sd300000000000000 + near_coord(1 << 30), any_speed(), any_speed());

    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
